// ===== sv/dfsac_pkg.sv =====
// Shared types and constants for the dual cache simulation unit.
// No dependencies.
package dfsac_pkg;
	localparam int CNT_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAY_COUNT   = 2'd2;

	localparam logic [5:0] OFFSET_RESET = 6'd6;
	localparam logic [3:0] INDEX_RESET  = 4'd0;
	localparam logic [3:0] WAYS_RESET   = 4'd1;

	typedef struct packed {
		logic pop;
		logic clearing;
	} dfsac_ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic en);
		logic [CNT_W-1:0] r;
		r = c;
		if (en && (c != {CNT_W{1'b1}})) begin
			r = c + CNT_W'(1);
		end
		return r;
	endfunction
endpackage

// ===== sv/dfsac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfsac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/dfsac_front.sv =====
// Front part: configuration registers, set and tag extraction for both caches,
// and a two-entry queue toward the back part. Depends on dfsac_pkg.
module dfsac_front import dfsac_pkg::*; #(
	parameter int ADDR_BITS = 48,
	parameter int MAX_SETS  = 1024,
	parameter int MAX_WAYS  = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]                        cfg_index,
	input  logic [CFG_DATA_W-1:0]                       cfg_data,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic                                        in_kind,
	input  logic [ADDR_BITS-1:0]                        in_addr,
	input  dfsac_ctl_t                                  ctl,
	output logic                                        q_valid,
	output logic                                        q_kind,
	output logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] q_set_a,
	output logic [ADDR_BITS-1:0]                        q_tag_a,
	output logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] q_set_b,
	output logic [ADDR_BITS-1:0]                        q_tag_b,
	output logic [$clog2(MAX_WAYS+1)-1:0]               ways
);
	localparam int SET_W = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
	localparam int IDX_MAX = ((1 << $clog2(MAX_SETS)) > MAX_SETS) ?
		$clog2(MAX_SETS) - 1 : $clog2(MAX_SETS);
	localparam int OFF_W = $clog2(ADDR_BITS + 1);
	localparam int WCW = $clog2(MAX_WAYS + 1);

	typedef struct packed {
		logic                 kind;
		logic [SET_W-1:0]     set_a;
		logic [ADDR_BITS-1:0] tag_a;
		logic [SET_W-1:0]     set_b;
		logic [ADDR_BITS-1:0] tag_b;
	} ent_t;

	logic [5:0] cfg_off_q;
	logic [3:0] cfg_idx_q;
	logic [3:0] cfg_way_q;
	logic [OFF_W-1:0] off_c, rem_c, idx_c, tbits_c;
	logic [SET_W-1:0] setmask_c;
	logic [ADDR_BITS-1:0] shifted_c;
	ent_t new_ent;
	ent_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_off_q <= OFFSET_RESET;
			cfg_idx_q <= INDEX_RESET;
			cfg_way_q <= WAYS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS: cfg_off_q <= cfg_data;
				CFG_INDEX_BITS:  cfg_idx_q <= cfg_data[3:0];
				CFG_WAY_COUNT:   cfg_way_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cfg_way_q == 4'd0) begin
			ways = WCW'(1);
		end else if (32'(cfg_way_q) > MAX_WAYS) begin
			ways = WCW'(MAX_WAYS);
		end else begin
			ways = WCW'(cfg_way_q);
		end
	end

	always_comb begin
		off_c = (32'(cfg_off_q) > ADDR_BITS) ? OFF_W'(ADDR_BITS) : OFF_W'(cfg_off_q);
		rem_c = OFF_W'(ADDR_BITS) - off_c;
		idx_c = OFF_W'(cfg_idx_q);
		if (idx_c > rem_c) begin
			idx_c = rem_c;
		end
		if (32'(idx_c) > IDX_MAX) begin
			idx_c = OFF_W'(IDX_MAX);
		end
		tbits_c = rem_c - idx_c;
		setmask_c = ~({SET_W{1'b1}} << idx_c);
		shifted_c = in_addr >> off_c;
		new_ent.kind = in_kind;
		new_ent.set_a = shifted_c[SET_W-1:0] & setmask_c;
		new_ent.tag_a = in_addr >> (off_c + idx_c);
		new_ent.set_b = SET_W'(in_addr >> (OFF_W'(ADDR_BITS) - idx_c)) & setmask_c;
		new_ent.tag_b = shifted_c & ~({ADDR_BITS{1'b1}} << tbits_c);
	end

	assign in_ready = (cnt_q != 2'd2) && !ctl.clearing;
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign q_kind  = ent_q[rp_q].kind;
	assign q_set_a = ent_q[rp_q].set_a;
	assign q_tag_a = ent_q[rp_q].tag_a;
	assign q_set_b = ent_q[rp_q].set_b;
	assign q_tag_b = ent_q[rp_q].tag_b;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (ctl.pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(ctl.pop);
		end
	end
endmodule

// ===== sv/dfsac_set.sv =====
// One cache: tag rows and fill/victim state in RAM, parallel tag compare
// and FIFO allocation. Depends on dfsac_pkg and dfsac_ram.
module dfsac_set import dfsac_pkg::*; #(
	parameter int ADDR_BITS = 48,
	parameter int MAX_SETS  = 1024,
	parameter int MAX_WAYS  = 8
) (
	input  logic                                        clk,
	input  logic                                        rd_en,
	input  logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] rd_set,
	input  logic                                        clr_en,
	input  logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] clr_set,
	input  logic                                        upd_en,
	input  logic [ADDR_BITS-1:0]                        tag,
	input  logic [$clog2(MAX_WAYS+1)-1:0]               ways,
	output logic                                        hit
);
	localparam int SET_W = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
	localparam int FILL_W = $clog2(MAX_WAYS + 1);
	localparam int VIC_W = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
	localparam int META_W = FILL_W + VIC_W;
	localparam int ROW_W = MAX_WAYS * ADDR_BITS;

	logic [SET_W-1:0] set_q;
	logic [ROW_W-1:0] row, new_row;
	logic [META_W-1:0] meta, meta_wdata;
	logic [FILL_W-1:0] fill, n, new_fill;
	logic [VIC_W-1:0] vic, v, slot, new_vic;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			set_q <= rd_set;
		end
	end

	assign fill = meta[FILL_W-1:0];
	assign vic = meta[META_W-1:FILL_W];

	always_comb begin
		n = (fill < ways) ? fill : ways;
		hit = 1'b0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if ((w < 32'(n)) && (row[w*ADDR_BITS +: ADDR_BITS] == tag)) begin
				hit = 1'b1;
			end
		end
		new_fill = fill;
		new_vic = vic;
		v = (32'(vic) >= 32'(ways)) ? VIC_W'(0) : vic;
		if (fill < ways) begin
			slot = VIC_W'(fill);
			new_fill = fill + FILL_W'(1);
		end else begin
			slot = v;
			new_vic = ((32'(v) + 1) >= 32'(ways)) ? VIC_W'(0) : v + VIC_W'(1);
		end
		new_row = row;
		new_row[slot*ADDR_BITS +: ADDR_BITS] = tag;
		meta_wdata = clr_en ? '0 : {new_vic, new_fill};
	end

	dfsac_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_tags (
		.clk   (clk),
		.we    (upd_en && !hit),
		.waddr (set_q),
		.wdata (new_row),
		.raddr (rd_set),
		.rdata (row)
	);

	dfsac_ram #(.WIDTH(META_W), .DEPTH(MAX_SETS)) u_meta (
		.clk   (clk),
		.we    (clr_en || (upd_en && !hit)),
		.waddr (clr_en ? clr_set : set_q),
		.wdata (meta_wdata),
		.raddr (rd_set),
		.rdata (meta)
	);
endmodule

// ===== sv/dfsac_back.sv =====
// Back part: clearing pass, lookup sequencing over both caches, saturating
// counters and the result register. Depends on dfsac_pkg and dfsac_set.
module dfsac_back import dfsac_pkg::*; #(
	parameter int ADDR_BITS = 48,
	parameter int MAX_SETS  = 1024,
	parameter int MAX_WAYS  = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        q_valid,
	input  logic                                        q_kind,
	input  logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] q_set_a,
	input  logic [ADDR_BITS-1:0]                        q_tag_a,
	input  logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] q_set_b,
	input  logic [ADDR_BITS-1:0]                        q_tag_b,
	input  logic [$clog2(MAX_WAYS+1)-1:0]               ways,
	output dfsac_ctl_t                                  ctl,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic                                        hit_a,
	output logic                                        hit_b,
	output logic [6*CNT_W-1:0]                          counts
);
	localparam int SET_W = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

	state_t state_q;
	logic [SET_W-1:0] clr_q;
	logic kind_q;
	logic [ADDR_BITS-1:0] tag_a_q, tag_b_q;
	logic out_valid_q, hit_a_q, hit_b_q;
	logic [CNT_W-1:0] hits_a_q, misses_a_q, writes_a_q, hits_b_q, misses_b_q, writes_b_q;
	logic start, look, ha, hb;

	assign start = (state_q == S_IDLE) && q_valid && (!out_valid_q || out_ready);
	assign look = state_q == S_LOOK;
	assign ctl.pop = start;
	assign ctl.clearing = state_q == S_CLEAR;

	dfsac_set #(.ADDR_BITS(ADDR_BITS), .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_a (
		.clk (clk), .rd_en (start), .rd_set (q_set_a), .clr_en (ctl.clearing),
		.clr_set (clr_q), .upd_en (look), .tag (tag_a_q), .ways (ways), .hit (ha)
	);

	dfsac_set #(.ADDR_BITS(ADDR_BITS), .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_b (
		.clk (clk), .rd_en (start), .rd_set (q_set_b), .clr_en (ctl.clearing),
		.clr_set (clr_q), .upd_en (look), .tag (tag_b_q), .ways (ways), .hit (hb)
	);

	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= q_kind;
			tag_a_q <= q_tag_a;
			tag_b_q <= q_tag_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
			hits_a_q <= '0;
			misses_a_q <= '0;
			writes_a_q <= '0;
			hits_b_q <= '0;
			misses_b_q <= '0;
			writes_b_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (32'(clr_q) == MAX_SETS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_a_q <= ha;
					hit_b_q <= hb;
					hits_a_q <= sat_inc(hits_a_q, ha);
					misses_a_q <= sat_inc(misses_a_q, !ha);
					writes_a_q <= sat_inc(writes_a_q, kind_q);
					hits_b_q <= sat_inc(hits_b_q, hb);
					misses_b_q <= sat_inc(misses_b_q, !hb);
					writes_b_q <= sat_inc(writes_b_q, kind_q);
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign hit_a = hit_a_q;
	assign hit_b = hit_b_q;
	assign counts = {writes_b_q, misses_b_q, hits_b_q, writes_a_q, misses_a_q, hits_a_q};

	a_look_needs_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		look |-> !out_valid_q) else $error("result register busy during lookup");
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> !ctl.pop) else $error("item taken during clearing pass");
	a_rise_after_look: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(look)) else $error("result without lookup");
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && hit_a_q) |-> (hits_a_q != '0)) else $error("hit not counted");
endmodule

// ===== sv/dual_fifo_set_assoc_cache_sim_unit.sv =====
// Top level: two set-associative FIFO-replacement caches looked up together.
// Path: the idle state takes an item from the front queue and reads its set rows; the lookup state
// compares tags, writes the rows and loads the output register; only then is a new item taken.
// Reset: asynchronous; a clearing pass over all MAX_SETS sets follows, during which no item is taken.
// Depends on dfsac_pkg, dfsac_front, dfsac_back.
module dual_fifo_set_assoc_cache_sim_unit import dfsac_pkg::*; #(
	parameter int ADDR_BITS = 48,
	parameter int MAX_SETS  = 1024,
	parameter int MAX_WAYS  = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((ADDR_BITS + 7) / 8) * 8-1:0] s_tdata,  // address
	input  logic                                s_tuser,  // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// hits_a, misses_a, writes_a, hits_b, misses_b, writes_b
	output logic [6*CNT_W-1:0]                  m_tdata,
	output logic [1:0]                          m_tuser   // hit_a, hit_b
);
	localparam int SET_W = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
	localparam int WCW = $clog2(MAX_WAYS + 1);

	dfsac_ctl_t ctl;
	logic q_valid, q_kind;
	logic [SET_W-1:0] q_set_a, q_set_b;
	logic [ADDR_BITS-1:0] q_tag_a, q_tag_b;
	logic [WCW-1:0] ways;

	dfsac_front #(.ADDR_BITS(ADDR_BITS), .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_front (
		.clk (clk), .arst_n (arst_n),
		.cfg_valid (cfg_valid), .cfg_ready (cfg_ready), .cfg_index (cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid), .in_ready (s_tready), .in_kind (s_tuser),
		.in_addr (s_tdata[ADDR_BITS-1:0]), .ctl (ctl),
		.q_valid (q_valid), .q_kind (q_kind), .q_set_a (q_set_a), .q_tag_a (q_tag_a),
		.q_set_b (q_set_b), .q_tag_b (q_tag_b), .ways (ways)
	);

	dfsac_back #(.ADDR_BITS(ADDR_BITS), .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
		.clk (clk), .arst_n (arst_n),
		.q_valid (q_valid), .q_kind (q_kind), .q_set_a (q_set_a), .q_tag_a (q_tag_a),
		.q_set_b (q_set_b), .q_tag_b (q_tag_b), .ways (ways), .ctl (ctl),
		.out_valid (m_tvalid), .out_ready (m_tready),
		.hit_a (m_tuser[0]), .hit_b (m_tuser[1]), .counts (m_tdata)
	);
endmodule
